>>> rtl/dptm_pkg.sv
// Shared types, register defaults, fault codes and the torque map for the
// dual pedal torque monitor. No dependencies.
package dptm_pkg;

    localparam int AngleW = 14;
    localparam int PosW   = 10;
    localparam int FaultW = 3;
    localparam int ModeW  = 3;
    localparam int PctW   = 7;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;

    localparam int TableEntries    = 16;
    localparam int LatchClearTicks = 50;

    localparam logic [PosW-1:0]   POS_FULL   = 10'd1000;
    localparam logic [AngleW-1:0] ANGLE_FULL = 14'd16383;
    localparam logic [PosW-1:0]   SEG_SPAN   = 10'd66;   // 1000 / 15

    // fault codes
    localparam logic [FaultW-1:0] FAULT_NONE    = 3'd0;
    localparam logic [FaultW-1:0] FAULT_SENSOR1 = 3'd1;
    localparam logic [FaultW-1:0] FAULT_SENSOR2 = 3'd2;
    localparam logic [FaultW-1:0] FAULT_PLAUS   = 3'd3;
    localparam logic [FaultW-1:0] FAULT_STUCK   = 3'd4;

    // vehicle modes that carry a cap
    localparam logic [ModeW-1:0] MODE_RUN      = 3'd1;
    localparam logic [ModeW-1:0] MODE_DEGRADED = 3'd2;
    localparam logic [ModeW-1:0] MODE_LIMP     = 3'd3;

    // register indexes
    localparam logic [CfgIdxW-1:0] CFG_PLAUS_THR  = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_PLAUS_DEB  = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_STUCK_THR  = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_STUCK_TICKS = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_RAMP_STEP  = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_CAP_RUN    = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_CAP_DEGR   = 3'd6;
    localparam logic [CfgIdxW-1:0] CFG_CAP_LIMP   = 3'd7;

    // register reset values
    localparam logic [13:0] RST_PLAUS_THR   = 14'd819;
    localparam logic [7:0]  RST_PLAUS_DEB   = 8'd2;
    localparam logic [13:0] RST_STUCK_THR   = 14'd10;
    localparam logic [15:0] RST_STUCK_TICKS = 16'd100;
    localparam logic [9:0]  RST_RAMP_STEP   = 10'd50;
    localparam logic [9:0]  RST_CAP_RUN     = 10'd1000;
    localparam logic [9:0]  RST_CAP_DEGR    = 10'd750;
    localparam logic [9:0]  RST_CAP_LIMP    = 10'd300;

    // controller to datapath commands, one step per cycle but for output stalls
    typedef struct packed {
        logic capture;
        logic check;
        logic scale;
        logic seg;
        logic div;
        logic shape;
        logic load_out;
    } dptm_cmd_t;

    function automatic logic [PosW-1:0] torque_map(input logic [3:0] idx);
        logic [PosW-1:0] v;
        case (idx)
            4'd0:    v = 10'd0;
            4'd1:    v = 10'd0;
            4'd2:    v = 10'd33;
            4'd3:    v = 10'd100;
            4'd4:    v = 10'd200;
            4'd5:    v = 10'd300;
            4'd6:    v = 10'd400;
            4'd7:    v = 10'd467;
            4'd8:    v = 10'd533;
            4'd9:    v = 10'd600;
            4'd10:   v = 10'd667;
            4'd11:   v = 10'd733;
            4'd12:   v = 10'd800;
            4'd13:   v = 10'd867;
            4'd14:   v = 10'd933;
            default: v = 10'd1000;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/dptm_ctrl.sv
// Sequencing controller for the pedal torque monitor: steps one transaction
// through the datapath and owns the output valid flag. Uses dptm_pkg.
module dptm_ctrl
    import dptm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output dptm_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCALE,
        ST_SEG,
        ST_DIV,
        ST_SHAPE,
        ST_OUT
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd          = '0;
        cmd.capture  = (state_reg == ST_IDLE) && in_valid;
        cmd.check    = (state_reg == ST_CHECK);
        cmd.scale    = (state_reg == ST_SCALE);
        cmd.seg      = (state_reg == ST_SEG);
        cmd.div      = (state_reg == ST_DIV);
        cmd.shape    = (state_reg == ST_SHAPE);
        cmd.load_out = (state_reg == ST_OUT) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // a new result replaces the one taken at this edge
            if ((state_reg == ST_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: state_reg <= ST_SCALE;
                ST_SCALE: state_reg <= ST_SEG;
                ST_SEG:   state_reg <= ST_DIV;
                ST_DIV:   state_reg <= ST_SHAPE;
                ST_SHAPE: state_reg <= ST_OUT;
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:  state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/dptm_dp.sv
// Datapath for the pedal torque monitor: config registers, fault detection
// state, position scaling, table interpolation, ramp, cap and fault latch.
// Uses dptm_pkg; driven by dptm_ctrl commands.
module dptm_dp
    import dptm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  dptm_cmd_t           cmd,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    input  logic [AngleW-1:0]   angle_one,
    input  logic [AngleW-1:0]   angle_two,
    input  logic                read_ok_one,
    input  logic                read_ok_two,
    input  logic [ModeW-1:0]    vehicle_mode,
    output logic [PosW-1:0]     pedal_travel,
    output logic [FaultW-1:0]   held_fault,
    output logic [FaultW-1:0]   fresh_fault,
    output logic [PosW-1:0]     torque_demand,
    output logic [PctW-1:0]     torque_percent,
    output logic                forward
);

    // configuration
    logic [13:0] plaus_thr_reg;
    logic [7:0]  plaus_deb_reg;
    logic [13:0] stuck_thr_reg;
    logic [15:0] stuck_ticks_reg;
    logic [9:0]  ramp_step_reg;
    logic [9:0]  cap_run_reg;
    logic [9:0]  cap_degr_reg;
    logic [9:0]  cap_limp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plaus_thr_reg   <= RST_PLAUS_THR;
            plaus_deb_reg   <= RST_PLAUS_DEB;
            stuck_thr_reg   <= RST_STUCK_THR;
            stuck_ticks_reg <= RST_STUCK_TICKS;
            ramp_step_reg   <= RST_RAMP_STEP;
            cap_run_reg     <= RST_CAP_RUN;
            cap_degr_reg    <= RST_CAP_DEGR;
            cap_limp_reg    <= RST_CAP_LIMP;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PLAUS_THR:   plaus_thr_reg   <= cfg_data[13:0];
                CFG_PLAUS_DEB:   plaus_deb_reg   <= cfg_data[7:0];
                CFG_STUCK_THR:   stuck_thr_reg   <= cfg_data[13:0];
                CFG_STUCK_TICKS: stuck_ticks_reg <= cfg_data;
                CFG_RAMP_STEP:   ramp_step_reg   <= cfg_data[9:0];
                CFG_CAP_RUN:     cap_run_reg     <= cfg_data[9:0];
                CFG_CAP_DEGR:    cap_degr_reg    <= cfg_data[9:0];
                CFG_CAP_LIMP:    cap_limp_reg    <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // captured transaction
    logic [AngleW-1:0] a1_reg, a2_reg;
    logic              ok1_reg, ok2_reg;
    logic [ModeW-1:0]  mode_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            a1_reg   <= angle_one;
            a2_reg   <= angle_two;
            ok1_reg  <= read_ok_one;
            ok2_reg  <= read_ok_two;
            mode_reg <= vehicle_mode;
        end
    end

    // ---------------- fault checks (CHECK step) ----------------
    logic [7:0]        mismatch_reg, mismatch_next;
    logic [15:0]       unchanged_reg, unchanged_next;
    logic              seeded_reg, seeded_next;
    logic              reported_reg, reported_next;
    logic [AngleW-1:0] last_a1_reg;
    logic [FaultW-1:0] fresh_reg, fresh_next;

    logic [AngleW-1:0] diff12, diff_stuck, base_a1;
    logic [7:0]        mismatch_inc;
    logic [15:0]       unchanged_inc;

    always_comb
    begin
        diff12 = (a1_reg >= a2_reg) ? (a1_reg - a2_reg) : (a2_reg - a1_reg);
        base_a1 = seeded_reg ? last_a1_reg : a1_reg;
        diff_stuck = (a1_reg >= base_a1) ? (a1_reg - base_a1) : (base_a1 - a1_reg);
        mismatch_inc  = (mismatch_reg == 8'hFF) ? mismatch_reg : mismatch_reg + 8'd1;
        unchanged_inc = (unchanged_reg == 16'hFFFF) ? unchanged_reg
                                                    : unchanged_reg + 16'd1;

        mismatch_next  = mismatch_reg;
        unchanged_next = unchanged_reg;
        seeded_next    = seeded_reg;
        reported_next  = reported_reg;

        if (!ok1_reg)
        begin
            fresh_next = FAULT_SENSOR1;
        end
        else if (!ok2_reg)
        begin
            fresh_next = FAULT_SENSOR2;
        end
        else
        begin
            fresh_next = FAULT_NONE;
        end

        if (fresh_next == FAULT_NONE)
        begin
            if (diff12 >= plaus_thr_reg)
            begin
                mismatch_next = mismatch_inc;
                if (mismatch_inc >= plaus_deb_reg)
                begin
                    fresh_next = FAULT_PLAUS;
                end
            end
            else
            begin
                mismatch_next = 8'd0;
            end
        end

        if (fresh_next == FAULT_NONE)
        begin
            seeded_next = 1'b1;
            if (diff_stuck < stuck_thr_reg)
            begin
                if (!reported_reg)
                begin
                    unchanged_next = unchanged_inc;
                    if (unchanged_inc >= stuck_ticks_reg)
                    begin
                        fresh_next    = FAULT_STUCK;
                        reported_next = 1'b1;
                    end
                end
            end
            else
            begin
                unchanged_next = 16'd0;
                reported_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mismatch_reg  <= '0;
            unchanged_reg <= '0;
            seeded_reg    <= 1'b0;
            reported_reg  <= 1'b0;
            last_a1_reg   <= '0;
            fresh_reg     <= FAULT_NONE;
        end
        else if (cmd.check)
        begin
            mismatch_reg  <= mismatch_next;
            unchanged_reg <= unchanged_next;
            seeded_reg    <= seeded_next;
            reported_reg  <= reported_next;
            last_a1_reg   <= a1_reg;
            fresh_reg     <= fresh_next;
        end
    end

    // average times 1000, also in CHECK step
    logic [AngleW:0] sum12;
    logic [23:0]     prod1_reg;

    assign sum12 = {1'b0, a1_reg} + {1'b0, a2_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.check)
        begin
            prod1_reg <= {10'd0, sum12[AngleW:1]} * {14'd0, POS_FULL};
        end
    end

    // ---------------- scale to 0..1000 (SCALE step) ----------------
    // x / 16383: x = q0*16383 + (x mod 2^14 + q0), remainder < 2*16383
    logic [9:0]    q0;
    logic [14:0]   rem15;
    logic [10:0]   pos_q;
    logic [PosW-1:0] pos_reg;

    always_comb
    begin
        q0    = prod1_reg[23:14];
        rem15 = {1'b0, prod1_reg[13:0]} + {5'd0, q0};
        pos_q = {1'b0, q0} + ((rem15 >= {1'b0, ANGLE_FULL}) ? 11'd1 : 11'd0);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scale)
        begin
            if (!(ok1_reg && ok2_reg))
            begin
                pos_reg <= '0;
            end
            else if (pos_q > {1'b0, POS_FULL})
            begin
                pos_reg <= POS_FULL;
            end
            else
            begin
                pos_reg <= pos_q[9:0];
            end
        end
    end

    // ---------------- segment and interpolation product (SEG step) ----------------
    logic [13:0]     p15;
    logic [3:0]      seg;
    logic [10:0]     seg_base;
    logic [6:0]      frac;
    logic [PosW-1:0] lo_v, hi_v, step_v;
    logic [16:0]     prod2_full;
    logic [12:0]     prod2_reg;
    logic [PosW-1:0] lo_reg;
    logic            full_reg;

    always_comb
    begin
        p15 = {4'd0, pos_reg} * 14'd15;
        seg = 4'd0;
        for (int k = 1; k < TableEntries - 1; k++)
        begin
            if (p15 >= 14'(k * 1000))
            begin
                seg = 4'(k);
            end
        end
        seg_base   = {7'd0, seg} * {1'b0, SEG_SPAN};
        frac       = 7'({1'b0, pos_reg} - seg_base);
        lo_v       = torque_map(seg);
        hi_v       = torque_map(seg + 4'd1);
        step_v     = hi_v - lo_v;     // table is non-decreasing
        prod2_full = {7'd0, step_v} * {10'd0, frac};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.seg)
        begin
            prod2_reg <= prod2_full[12:0];
            lo_reg    <= lo_v;
            full_reg  <= (pos_reg >= POS_FULL);
        end
    end

    // ---------------- divide by 66 (DIV step) ----------------
    // floor(p/66) = (p * 15888) >> 20 for p < 8192
    logic [26:0] recip_prod;
    logic [6:0]  q66_reg;

    assign recip_prod = {14'd0, prod2_reg} * 27'd15888;

    always_ff @(posedge clk)
    begin
        if (cmd.div)
        begin
            q66_reg <= recip_prod[26:20];
        end
    end

    // ---------------- ramp, cap, latch (SHAPE step) ----------------
    logic [PosW-1:0]   last_torque_reg;
    logic              latch_reg;
    logic [7:0]        clean_reg;
    logic [FaultW-1:0] hold_reg;
    logic [PosW-1:0]   torque_reg;

    logic [10:0]     interp;
    logic [PosW-1:0] mapped, ramped, mode_cap, capped, torque_next;
    logic [10:0]     ramp_lim;
    logic [7:0]      clean_inc;
    logic            latch_next;
    logic [7:0]      clean_next;
    logic [FaultW-1:0] hold_next;

    always_comb
    begin
        interp = {1'b0, lo_reg} + {4'd0, q66_reg};
        if (full_reg || interp > {1'b0, POS_FULL})
        begin
            mapped = POS_FULL;
        end
        else
        begin
            mapped = interp[9:0];
        end

        ramp_lim = {1'b0, last_torque_reg} + {1'b0, ramp_step_reg};
        if (mapped > last_torque_reg && {1'b0, mapped} > ramp_lim)
        begin
            ramped = ramp_lim[9:0];   // below mapped, so fits
        end
        else
        begin
            ramped = mapped;
        end

        unique case (mode_reg)
            MODE_RUN:      mode_cap = cap_run_reg;
            MODE_DEGRADED: mode_cap = cap_degr_reg;
            MODE_LIMP:     mode_cap = cap_limp_reg;
            default:       mode_cap = '0;
        endcase
        capped = (ramped > mode_cap) ? mode_cap : ramped;

        clean_inc   = (clean_reg == 8'hFF) ? clean_reg : clean_reg + 8'd1;
        latch_next  = latch_reg;
        clean_next  = clean_reg;
        hold_next   = hold_reg;
        torque_next = capped;

        if (fresh_reg != FAULT_NONE)
        begin
            hold_next  = fresh_reg;
            latch_next = 1'b1;
            clean_next = 8'd0;
            // stuck tick latches but still passes torque this once
            if (fresh_reg != FAULT_STUCK)
            begin
                torque_next = '0;
            end
        end
        else if (latch_reg)
        begin
            if (clean_inc >= 8'(LatchClearTicks))
            begin
                latch_next = 1'b0;
                clean_next = 8'd0;
                hold_next  = FAULT_NONE;
            end
            else
            begin
                clean_next  = clean_inc;
                torque_next = '0;
            end
        end
        else
        begin
            hold_next = FAULT_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_torque_reg <= '0;
            latch_reg       <= 1'b0;
            clean_reg       <= '0;
            hold_reg        <= FAULT_NONE;
        end
        else if (cmd.shape)
        begin
            last_torque_reg <= ramped;
            latch_reg       <= latch_next;
            clean_reg       <= clean_next;
            hold_reg        <= hold_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.shape)
        begin
            torque_reg <= torque_next;
        end
    end

    // ---------------- percent and output register (OUT step) ----------------
    // t / 10 = (t * 205) >> 11 for t < 1024
    logic [17:0]     pct_prod;
    logic [PctW-1:0] pct;

    logic [PosW-1:0]   pos_out_reg;
    logic [FaultW-1:0] held_out_reg;
    logic [FaultW-1:0] fresh_out_reg;
    logic [PosW-1:0]   torque_out_reg;
    logic [PctW-1:0]   pct_out_reg;
    logic              fwd_out_reg;

    assign pct_prod = {8'd0, torque_reg} * 18'd205;
    assign pct = (pct_prod[17:11] > 7'd100) ? 7'd100 : pct_prod[17:11];

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            pos_out_reg    <= pos_reg;
            held_out_reg   <= hold_reg;
            fresh_out_reg  <= fresh_reg;
            torque_out_reg <= torque_reg;
            pct_out_reg    <= pct;
            fwd_out_reg    <= (torque_reg != '0);
        end
    end

    assign pedal_travel   = pos_out_reg;
    assign held_fault     = held_out_reg;
    assign fresh_fault    = fresh_out_reg;
    assign torque_demand  = torque_out_reg;
    assign torque_percent = pct_out_reg;
    assign forward        = fwd_out_reg;

endmodule

>>> rtl/dual_pedal_torque_monitor_unit.sv
// Top level of the dual pedal torque monitor: controller plus datapath.
// Depends on dptm_pkg, dptm_ctrl and dptm_dp.
//
// Usage:
//  - Input channel (in_valid/in_ready) carries one pedal tick per transaction:
//    both angles, both read-ok flags and the vehicle mode.
//  - Output channel (out_valid/out_ready) returns exactly one result per tick:
//    position, held and fresh fault codes, torque, percent and direction.
//  - Config port: cfg_we with cfg_index/cfg_data writes one register at once;
//    write only while no tick is in flight.
//  - Order: an accepted tick passes CHECK, SCALE, SEG, DIV, SHAPE and OUT;
//    out_valid rises as OUT loads the result, if the output register is free.
//  - Sequencing: one tick at a time (accept, then six sequenced steps:
//    fault check, scaling divide, segment lookup, interpolation divide,
//    ramp/cap/latch, output load), one step per cycle but for output stalls.
//  - Stall: if the previous result is still unread the sequencer holds in its
//    last step and in_ready stays low; the computed tick is kept, not lost.
//    A new tick can be accepted while a finished result waits to be taken.
//  - Reset (rst_n low, async): registers return to their defaults, all
//    monitor state clears, no result is pending.
module dual_pedal_torque_monitor_unit
    import dptm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // input channel
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [AngleW-1:0]   angle_one,
    input  logic [AngleW-1:0]   angle_two,
    input  logic                read_ok_one,
    input  logic                read_ok_two,
    input  logic [ModeW-1:0]    vehicle_mode,
    // output channel
    output logic                out_valid,
    input  logic                out_ready,
    output logic [PosW-1:0]     pedal_travel,
    output logic [FaultW-1:0]   held_fault,
    output logic [FaultW-1:0]   fresh_fault,
    output logic [PosW-1:0]     torque_demand,
    output logic [PctW-1:0]     torque_percent,
    output logic                forward,
    // configuration writes
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data
);

    dptm_cmd_t cmd;

    // step sequencer; in_ready only while idle
    dptm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // all arithmetic, monitor state and output payload registers
    dptm_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .angle_one      (angle_one),
        .angle_two      (angle_two),
        .read_ok_one    (read_ok_one),
        .read_ok_two    (read_ok_two),
        .vehicle_mode   (vehicle_mode),
        .pedal_travel   (pedal_travel),
        .held_fault     (held_fault),
        .fresh_fault    (fresh_fault),
        .torque_demand  (torque_demand),
        .torque_percent (torque_percent),
        .forward        (forward)
    );

endmodule
